[rtl/tlr_pkg.sv]
// Shared types and constants of the thick line rasterizer.
// Used by every module of the block but tlr_fifo; depends on nothing.
package tlr_pkg;

  localparam int DIM_W = 12;
  localparam int PEN_W = 4;
  localparam int PIX_W = 11;
  localparam int ADDR_W = 22;
  localparam int COLOR_W = 32;
  localparam int REG_INDEX_W = 2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET = 12'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
  localparam logic [PEN_W-1:0] PEN_WIDTH_RESET = 4'd1;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PEN_WIDTH    = 2'd2
  } reg_index_t;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  typedef enum logic {
    CTR_IDLE,
    CTR_DIV
  } center_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    logic [PEN_W-1:0] pen;
    logic             wr;
  } frame_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last_of_point;
    logic               line_done;
  } pixel_t;

endpackage

[rtl/thick_line_rasterizer_wrap_core.sv]
// Top level of the thick wrapping line rasterizer: configuration registers,
// front end, point queue, back end and pixel queue. Uses tlr_pkg.
//
//   channel  | handshake               | word
//   ---------+-------------------------+-----------------------------------------
//   input    | push / full             | action, endpoints, line_color
//   result   | empty / pop             | pixel_x/y, pixel_address, color, flags
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A start word emits nothing. An advance word on an active line emits p*p pixels,
// one pixel per cycle while the pixel queue has room, p being the clamped pen width,
// set by the pen sweep counters. A point more than one step from the previous point,
// and the first point after a register write, go through the bit-serial remainder
// units; other points reuse the previous wrapped point.
// Reset loads 640, 480 and 1 into the registers; no clearing pass is needed.
// full rises when the two-entry point queue is full; a withheld pop stalls the pixel path.
module thick_line_rasterizer_wrap_core import tlr_pkg::*; #(
  parameter int MAX_PEN = 8,
  parameter int MAX_FRAME_DIM = 2048,
  parameter int COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOR_W-1:0]           line_color,
  output logic                         empty,
  input  logic                         pop,
  output logic [PIX_W-1:0]             pixel_x,
  output logic [PIX_W-1:0]             pixel_y,
  output logic [ADDR_W-1:0]            pixel_address,
  output logic [COLOR_W-1:0]           pixel_color,
  output logic                         last_of_point,
  output logic                         line_done,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [REG_INDEX_W-1:0]       cfg_index,
  input  logic [DIM_W-1:0]             cfg_data
);

  localparam int CMD_W = 2 * COORD_BITS + COLOR_W + 1;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  logic [DIM_W-1:0]             frame_width, frame_height;
  logic [PEN_W-1:0]             pen_width;
  frame_cfg_t                   cfg;
  logic                         cfg_wr;
  logic                         accept;

  logic                         cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic signed [COORD_BITS-1:0] f_x, f_y;
  logic [COLOR_W-1:0]           f_color;
  logic                         f_last;
  logic [CMD_W-1:0]             cmd_din, cmd_dout;

  logic                         out_push, out_full;
  pixel_t                       out_pixel, out_word;
  logic [$bits(pixel_t)-1:0]    out_dout;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      pen_width <= PEN_WIDTH_RESET;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_PEN_WIDTH:    pen_width <= cfg_data[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.wr = cfg_wr;
    if (frame_width == '0) begin
      cfg.fw = DIM_W'(1);
    end else if (int'(frame_width) > MAX_FRAME_DIM) begin
      cfg.fw = DIM_W'(MAX_FRAME_DIM);
    end else begin
      cfg.fw = frame_width;
    end
    if (frame_height == '0) begin
      cfg.fh = DIM_W'(1);
    end else if (int'(frame_height) > MAX_FRAME_DIM) begin
      cfg.fh = DIM_W'(MAX_FRAME_DIM);
    end else begin
      cfg.fh = frame_height;
    end
    if (pen_width == '0) begin
      cfg.pen = PEN_W'(1);
    end else if (int'(pen_width) > MAX_PEN) begin
      cfg.pen = PEN_W'(MAX_PEN);
    end else begin
      cfg.pen = pen_width;
    end
  end

  assign full = cmd_full;
  assign accept = push && !full;

  tlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .action(action),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .line_color(line_color), .cmd_push(cmd_push), .cmd_x(f_x), .cmd_y(f_y),
    .cmd_color(f_color), .cmd_last(f_last)
  );

  assign cmd_din = {f_last, f_color, f_y, f_x};

  tlr_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk(clk), .rst(rst), .push(cmd_push), .din(cmd_din), .full(cmd_full),
    .pop(cmd_pop), .dout(cmd_dout), .empty(cmd_empty)
  );

  tlr_back #(.COORD_BITS(COORD_BITS), .MAX_PEN(MAX_PEN)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
    .cmd_x(cmd_dout[COORD_BITS-1:0]),
    .cmd_y(cmd_dout[2*COORD_BITS-1:COORD_BITS]),
    .cmd_color(cmd_dout[2*COORD_BITS+COLOR_W-1:2*COORD_BITS]),
    .cmd_last(cmd_dout[CMD_W-1]),
    .out_full(out_full), .out_push(out_push), .out_pixel(out_pixel)
  );

  tlr_fifo #(.WIDTH($bits(pixel_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk(clk), .rst(rst), .push(out_push), .din(out_pixel), .full(out_full),
    .pop(pop), .dout(out_dout), .empty(empty)
  );

  assign out_word = pixel_t'(out_dout);
  assign pixel_x = out_word.pix_x;
  assign pixel_y = out_word.pix_y;
  assign pixel_address = out_word.addr;
  assign pixel_color = out_word.color;
  assign last_of_point = out_word.last_of_point;
  assign line_done = out_word.line_done;

endmodule

[rtl/tlr_fifo.sv]
// Small register queue with full and empty flags.
// Depends on nothing; used for the point queue and the pixel queue.
module tlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[rtl/tlr_front.sv]
// Front end: takes start and advance words, sets up and steps the Bresenham line.
// Uses tlr_pkg; feeds one point word per advance on an active line into the point queue.
module tlr_front import tlr_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [COLOR_W-1:0]           line_color,
  output logic                         cmd_push,
  output logic signed [COORD_BITS-1:0] cmd_x,
  output logic signed [COORD_BITS-1:0] cmd_y,
  output logic [COLOR_W-1:0]           cmd_color,
  output logic                         cmd_last
);

  localparam int ERR_W = COORD_BITS + 3;

  logic                         line_active;
  logic signed [COORD_BITS-1:0] current_x;
  logic signed [COORD_BITS-1:0] current_y;
  logic signed [COORD_BITS-1:0] final_x;
  logic signed [COORD_BITS-1:0] final_y;
  logic signed [ERR_W-1:0]      error_term;
  logic signed [ERR_W-1:0]      error_step_keep;
  logic signed [ERR_W-1:0]      error_step_move;
  logic                         major_is_x;
  logic                         step_left;
  logic [COLOR_W-1:0]           held_color;

  logic                         do_start;
  logic                         swap;
  logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
  logic signed [COORD_BITS:0]   dx_raw, dx_abs, dy;
  logic                         left_new, xmaj_new;
  logic signed [ERR_W-1:0]      dxe, dye, keep_new, move_new, init_new;
  logic                         last_point, move;
  logic signed [COORD_BITS-1:0] x_stepped, y_stepped;

  assign do_start = accept && (action_t'(action) == ACT_START);
  assign cmd_push = accept && (action_t'(action) == ACT_ADVANCE) && line_active;
  assign last_point = major_is_x ? (current_x == final_x) : (current_y == final_y);
  assign cmd_x = current_x;
  assign cmd_y = current_y;
  assign cmd_color = held_color;
  assign cmd_last = last_point;

  always_comb begin
    swap = start_y > end_y;
    xa = swap ? end_x : start_x;
    ya = swap ? end_y : start_y;
    xb = swap ? start_x : end_x;
    yb = swap ? start_y : end_y;
    dx_raw = (COORD_BITS + 1)'(xb) - (COORD_BITS + 1)'(xa);
    dy = (COORD_BITS + 1)'(yb) - (COORD_BITS + 1)'(ya);
    left_new = !(dx_raw > 0);
    dx_abs = left_new ? -dx_raw : dx_raw;
    xmaj_new = dx_abs > dy;
    dxe = ERR_W'(dx_abs);
    dye = ERR_W'(dy);
    keep_new = xmaj_new ? (dye <<< 1) : (dxe <<< 1);
    move_new = xmaj_new ? ((dye - dxe) <<< 1) : ((dxe - dye) <<< 1);
    init_new = keep_new - (xmaj_new ? dxe : dye);
  end

  always_comb begin
    move = !error_term[ERR_W-1];
    x_stepped = step_left ? COORD_BITS'(current_x - 1'b1) : COORD_BITS'(current_x + 1'b1);
    y_stepped = COORD_BITS'(current_y + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (do_start) begin
      line_active <= 1'b1;
    end else if (cmd_push && last_point) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      current_x <= xa;
      current_y <= ya;
      final_x <= xb;
      final_y <= yb;
      error_term <= init_new;
      error_step_keep <= keep_new;
      error_step_move <= move_new;
      major_is_x <= xmaj_new;
      step_left <= left_new;
      held_color <= line_color;
    end else if (cmd_push && !last_point) begin
      if (major_is_x) begin
        current_x <= x_stepped;
        if (move) begin
          current_y <= y_stepped;
        end
      end else begin
        current_y <= y_stepped;
        if (move) begin
          current_x <= x_stepped;
        end
      end
      error_term <= error_term + (move ? error_step_move : error_step_keep);
    end
  end

endmodule

[rtl/tlr_wrap_div.sv]
// Bit-serial remainder unit: reduces a signed coordinate into 0..modulus-1.
// Uses tlr_pkg; one quotient bit per cycle, done pulses after the last bit.
module tlr_wrap_div import tlr_pkg::*; #(
  parameter int COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] value,
  input  logic [DIM_W-1:0]             modulus,
  output logic                         done,
  output logic [DIM_W-1:0]             result
);

  localparam int CNT_W = $clog2(COORD_BITS + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] mag;
  logic [DIM_W-1:0]      rem;
  logic                  neg;
  logic [DIM_W:0]        trial;

  assign trial = {rem, mag[COORD_BITS-1]};
  assign result = (neg && (rem != '0)) ? DIM_W'(modulus - rem) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(COORD_BITS);
      end else if (busy) begin
        cnt <= CNT_W'(cnt - 1'b1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= value[COORD_BITS-1] ? $unsigned(COORD_BITS'(-value)) : $unsigned(value);
      rem <= '0;
      neg <= value[COORD_BITS-1];
    end else if (busy) begin
      mag <= mag << 1;
      rem <= (trial >= {1'b0, modulus}) ? DIM_W'(trial - {1'b0, modulus}) : DIM_W'(trial);
    end
  end

endmodule

[rtl/tlr_back.sv]
// Back end: wraps each line point into the frame, sweeps the pen square and
// forms pixel addresses. Uses tlr_pkg and two tlr_wrap_div units.
module tlr_back import tlr_pkg::*; #(
  parameter int COORD_BITS = 13,
  parameter int MAX_PEN = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  frame_cfg_t                   cfg,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  input  logic signed [COORD_BITS-1:0] cmd_x,
  input  logic signed [COORD_BITS-1:0] cmd_y,
  input  logic [COLOR_W-1:0]           cmd_color,
  input  logic                         cmd_last,
  input  logic                         out_full,
  output logic                         out_push,
  output pixel_t                       out_pixel
);

  localparam int KMAX = MAX_PEN / 2;
  localparam int CNT_W = (MAX_PEN > 1) ? $clog2(MAX_PEN) : 1;

  function automatic logic [DIM_W-1:0] wrap_inc(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] m);
    logic [DIM_W:0] s;
    s = {1'b0, v} + 1'b1;
    return (s == {1'b0, m}) ? '0 : DIM_W'(s);
  endfunction

  function automatic logic [DIM_W-1:0] wrap_dec(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] m);
    return (v == '0) ? DIM_W'(m - 1'b1) : DIM_W'(v - 1'b1);
  endfunction

  function automatic logic [DIM_W-1:0] wrap_back(input logic [DIM_W-1:0] c,
                                                input logic [PEN_W-1:0] k,
                                                input logic [DIM_W-1:0] m);
    logic signed [DIM_W:0] v;
    v = $signed({1'b0, c}) - $signed({{(DIM_W + 1 - PEN_W){1'b0}}, k});
    for (int i = 0; i < KMAX; i++) begin
      if (v < 0) begin
        v = v + $signed({1'b0, m});
      end
    end
    return DIM_W'(v);
  endfunction

  center_state_t                state, state_next;
  logic                         center_valid;
  logic                         cache_valid;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic [DIM_W-1:0]             ctr_x, ctr_y;
  logic [COLOR_W-1:0]           ctr_color;
  logic                         ctr_last;

  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic                         hit;
  logic [DIM_W-1:0]             hit_x, hit_y;
  logic                         take;
  logic                         div_start, div_done, done_x, done_y;
  logic [DIM_W-1:0]             div_x, div_y;

  logic                         sw_valid;
  logic [DIM_W-1:0]             sx, sy, row_x;
  logic [CNT_W-1:0]             col, row;
  logic [COLOR_W-1:0]           sw_color;
  logic                         sw_last;
  logic [PEN_W-1:0]             pen_m1, pen_k;
  logic                         col_end, row_end, pix_last;
  logic [DIM_W-1:0]             corner_x, corner_y;

  logic                         adv;
  logic                         m_valid;
  logic [DIM_W-1:0]             m_px, m_py;
  logic [2*DIM_W-1:0]           m_prod, addr_full;
  logic [COLOR_W-1:0]           m_color;
  logic                         m_lop, m_ld;

  always_comb begin
    diff_x = (COORD_BITS + 1)'(cmd_x) - (COORD_BITS + 1)'(prev_x);
    diff_y = (COORD_BITS + 1)'(cmd_y) - (COORD_BITS + 1)'(prev_y);
    hit = cache_valid && (diff_x >= -1) && (diff_x <= 1) && (diff_y >= -1) && (diff_y <= 1);
    hit_x = (diff_x == 0) ? ctr_x : ((diff_x > 0) ? wrap_inc(ctr_x, cfg.fw) : wrap_dec(ctr_x, cfg.fw));
    hit_y = (diff_y == 0) ? ctr_y : ((diff_y > 0) ? wrap_inc(ctr_y, cfg.fh) : wrap_dec(ctr_y, cfg.fh));
  end

  assign take = center_valid && (!sw_valid || (adv && pix_last));
  assign div_done = done_x && done_y;
  assign div_start = cmd_pop && !hit;

  always_comb begin
    state_next = state;
    cmd_pop = 1'b0;
    unique case (state)
      CTR_IDLE: begin
        if (!cmd_empty && (!center_valid || take)) begin
          cmd_pop = 1'b1;
          if (!hit) begin
            state_next = CTR_DIV;
          end
        end
      end
      CTR_DIV: begin
        if (div_done) begin
          state_next = CTR_IDLE;
        end
      end
      default: state_next = CTR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  tlr_wrap_div #(.COORD_BITS(COORD_BITS)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .value(cmd_x), .modulus(cfg.fw),
    .done(done_x), .result(div_x)
  );

  tlr_wrap_div #(.COORD_BITS(COORD_BITS)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .value(cmd_y), .modulus(cfg.fh),
    .done(done_y), .result(div_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      center_valid <= 1'b0;
      cache_valid <= 1'b0;
    end else begin
      if (cmd_pop && hit) begin
        center_valid <= 1'b1;
      end else if ((state == CTR_DIV) && div_done) begin
        center_valid <= 1'b1;
      end else if (take) begin
        center_valid <= 1'b0;
      end
      if (cfg.wr || div_start) begin
        cache_valid <= 1'b0;
      end else if ((state == CTR_DIV) && div_done) begin
        cache_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      prev_x <= cmd_x;
      prev_y <= cmd_y;
      ctr_color <= cmd_color;
      ctr_last <= cmd_last;
      if (hit) begin
        ctr_x <= hit_x;
        ctr_y <= hit_y;
      end
    end else if ((state == CTR_DIV) && div_done) begin
      ctr_x <= div_x;
      ctr_y <= div_y;
    end
  end

  always_comb begin
    pen_m1 = PEN_W'(cfg.pen - 1'b1);
    pen_k = cfg.pen >> 1;
    col_end = PEN_W'(col) >= pen_m1;
    row_end = PEN_W'(row) >= pen_m1;
    pix_last = col_end && row_end;
    corner_x = wrap_back(ctr_x, pen_k, cfg.fw);
    corner_y = wrap_back(ctr_y, pen_k, cfg.fh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_valid <= 1'b0;
    end else if (take) begin
      sw_valid <= 1'b1;
    end else if (sw_valid && adv && pix_last) begin
      sw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sx <= corner_x;
      row_x <= corner_x;
      sy <= corner_y;
      col <= '0;
      row <= '0;
      sw_color <= ctr_color;
      sw_last <= ctr_last;
    end else if (sw_valid && adv) begin
      if (col_end) begin
        col <= '0;
        sx <= row_x;
        sy <= wrap_inc(sy, cfg.fh);
        row <= CNT_W'(row + 1'b1);
      end else begin
        col <= CNT_W'(col + 1'b1);
        sx <= wrap_inc(sx, cfg.fw);
      end
    end
  end

  assign adv = !m_valid || !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= sw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_px <= sx;
      m_py <= sy;
      m_prod <= cfg.fw * sy;
      m_color <= sw_color;
      m_lop <= pix_last;
      m_ld <= pix_last && sw_last;
    end
  end

  assign addr_full = m_prod + (2 * DIM_W)'(m_px);
  assign out_push = m_valid && !out_full;

  always_comb begin
    out_pixel.pix_x = m_px[PIX_W-1:0];
    out_pixel.pix_y = m_py[PIX_W-1:0];
    out_pixel.addr = addr_full[ADDR_W-1:0];
    out_pixel.color = m_color;
    out_pixel.last_of_point = m_lop;
    out_pixel.line_done = m_ld;
  end

  a_done_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == CTR_DIV))
    else $error("remainder result arrived outside a divide");

  a_center_after_div: assert property (@(posedge clk) disable iff (rst)
    ((state == CTR_DIV) && div_done) |=> center_valid)
    else $error("finished divide did not load the center register");

  a_sweep_stops: assert property (@(posedge clk) disable iff (rst)
    (sw_valid && adv && pix_last && !center_valid) |=> !sw_valid)
    else $error("pen sweep kept running past its last pixel");

endmodule
